[design/sdws_pkg.sv]
// Shared constants and types for the signed duty window sum block.
package sdws_pkg;

    // Window geometry and field widths.
    localparam int WINDOW_LEN = 50;
    localparam int SLOT_W     = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int DUTY_W     = 15;
    localparam int ENTRY_W    = DUTY_W + 1;
    localparam int SUM_W      = 22;

    typedef logic [SLOT_W-1:0]         slot_t;
    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic [SUM_W-1:0]          sum_t;

    // Direction mode codes.
    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_CW   = 2'd1,
        MODE_CCW  = 2'd2
    } mode_t;

    // Read request toward the window store.
    typedef struct packed {
        logic  en;
        slot_t addr;
    } win_rd_t;

    // Write request toward the window store.
    typedef struct packed {
        logic   en;
        slot_t  addr;
        entry_t data;
    } win_wr_t;

endpackage

[design/signed_duty_window_sum_with_direction.sv]
// Top level of the signed duty window sum with direction mode.
//
// Capture events enter on the s_ channel, one request per event; results leave
// on the m_ channel, exactly one per event and in order. A duty edge writes the
// duty into a shared circular window (negated for the counter-clockwise
// channel) and updates the running sum by removing the overwritten entry. The
// direction mode leaves stop on a duty edge with a start pulse and returns to
// stop on a lone overflow of the active channel (no period or duty edge) with a stop pulse.
//
// The accepting edge registers the event in the update stage and issues the
// window memory read; the edge at which that stage advances registers the
// update in the output register. Throughput is one event per cycle while the
// receiver does not stall; the next slot is always known, so the memory read is
// issued at acceptance and the write-back happens when the update stage advances.
// Reset clears the mode, the sum, the slot pointer and the valid bits of the
// window, so the window reads as all zero at once without a clearing pass.
// When the receiver stalls, the result waits in the output register, one more
// event waits in the update stage, and s_tready drops only when both are full.
module signed_duty_window_sum_with_direction
    import sdws_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // period_edge, duty_edge, overflow, duty[14:0], zero fill
    input  logic        s_tuser,   // channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sum_updated, window_sum[21:0], mode[1:0],
                                   // start_pulse, stop_pulse, zero fill
);

    function automatic slot_t slot_inc(slot_t s);
        slot_t r;
        if (s == slot_t'(WINDOW_LEN - 1)) begin
            r = '0;
        end else begin
            r = s + 1'b1;
        end
        return r;
    endfunction

    logic              accept;
    logic              adv;
    slot_t             slot_reg;
    logic              s1_valid_reg;
    logic              s1_ch_reg;
    logic              s1_per_reg;
    logic              s1_dedge_reg;
    logic              s1_ovf_reg;
    logic [DUTY_W-1:0] s1_duty_reg;
    slot_t             s1_slot_reg;
    sum_t              sum_reg;
    sum_t              sum_next;
    mode_t             mode_reg;
    mode_t             mode_next;
    mode_t             chan_mode;
    logic              start_pulse;
    logic              stop_pulse;
    entry_t            duty_ext;
    entry_t            new_entry;
    entry_t            old_entry;
    logic              m_valid_reg;
    logic [31:0]       m_data_reg;
    logic [31:0]       m_data_next;
    win_rd_t           win_rd;
    win_wr_t           win_wr;

    // Handshake: the update stage moves when the output register is empty or being taken.
    assign accept   = s_tvalid && s_tready;
    assign adv      = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Window store requests.
    always_comb begin
        win_rd.en   = accept;
        win_rd.addr = slot_reg;
        win_wr.en   = adv && s1_dedge_reg;
        win_wr.addr = s1_slot_reg;
        win_wr.data = new_entry;
    end

    sdws_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd        (win_rd),
        .wr        (win_wr),
        .old_entry (old_entry)
    );

    // Signed sample and running sum update.
    always_comb begin
        duty_ext  = entry_t'({1'b0, s1_duty_reg});
        new_entry = s1_ch_reg ? -duty_ext : duty_ext;
        sum_next  = sum_reg;
        if (s1_dedge_reg) begin
            sum_next = sum_reg
                     - {{(SUM_W - ENTRY_W){old_entry[ENTRY_W-1]}}, old_entry}
                     + {{(SUM_W - ENTRY_W){new_entry[ENTRY_W-1]}}, new_entry};
        end
    end

    // Direction mode: start on a duty edge, stop on a lone overflow of the
    // active channel.
    always_comb begin
        chan_mode   = s1_ch_reg ? MODE_CCW : MODE_CW;
        mode_next   = mode_reg;
        start_pulse = 1'b0;
        stop_pulse  = 1'b0;
        if (s1_dedge_reg && (mode_reg == MODE_STOP)) begin
            mode_next   = chan_mode;
            start_pulse = 1'b1;
        end
        if (s1_ovf_reg && !s1_per_reg && !s1_dedge_reg && (mode_reg == chan_mode)) begin
            mode_next  = MODE_STOP;
            stop_pulse = 1'b1;
        end
        m_data_next = {5'b0, stop_pulse, start_pulse, mode_next, sum_next, s1_dedge_reg};
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            sum_reg      <= '0;
            mode_reg     <= MODE_STOP;
        end else begin
            if (accept && s_tdata[1]) begin
                slot_reg <= slot_inc(slot_reg);
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (adv) begin
                m_valid_reg <= 1'b1;
                sum_reg     <= sum_next;
                mode_reg    <= mode_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers of the update stage and the output.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ch_reg    <= s_tuser;
            s1_per_reg   <= s_tdata[0];
            s1_dedge_reg <= s_tdata[1];
            s1_ovf_reg   <= s_tdata[2];
            s1_duty_reg  <= s_tdata[17:3];
            s1_slot_reg  <= slot_reg;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    // A start pulse always comes with a sum update and an active mode.
    a_start_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[25]) |-> (m_data_reg[0] && (m_data_reg[24:23] != MODE_STOP)))
        else $error("start pulse without update or active mode");

    // A stop pulse leaves the mode at stop and never comes with an update.
    a_stop_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[26]) |-> ((m_data_reg[24:23] == MODE_STOP) && !m_data_reg[0]))
        else $error("stop pulse with wrong mode or update");

    // The slot pointer stays inside the window.
    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= slot_t'(WINDOW_LEN - 1))
        else $error("write slot out of range");

    // Each accepted duty edge moves the slot pointer by one, with wrap.
    a_slot_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tdata[1]) |=> (slot_reg == slot_inc($past(slot_reg))))
        else $error("write slot did not advance");

    // A stalled event keeps its place and slot in the update stage.
    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(s1_slot_reg)))
        else $error("stalled event lost from update stage");

endmodule

[design/sdws_window.sv]
// Circular window store: synchronous memory with reset valid bits and write forwarding.
module sdws_window
    import sdws_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  win_rd_t rd,
    input  win_wr_t wr,
    output entry_t  old_entry
);

    entry_t                mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0] valid_reg;
    entry_t                rd_data_reg;
    entry_t                fwd_data_reg;
    logic                  rd_valid_reg;
    logic                  fwd_sel_reg;

    // Memory array with a registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en) begin
            rd_data_reg  <= mem[rd.addr];
            fwd_data_reg <= wr.data;
        end
    end

    // Valid bits make every entry read as zero after reset; a write to the
    // entry being read in the same cycle is forwarded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr.addr] <= 1'b1;
            end
            if (rd.en) begin
                rd_valid_reg <= valid_reg[rd.addr];
                fwd_sel_reg  <= wr.en && (wr.addr == rd.addr);
            end
        end
    end

    // Resolve the value that the new sample replaces.
    assign old_entry = fwd_sel_reg  ? fwd_data_reg :
                       rd_valid_reg ? rd_data_reg  : '0;

endmodule

[tb/tb.sv]
// Self-checking testbench for the signed duty window sum with direction mode.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import sdws_pkg::*;

    // One predicted result of a capture event.
    typedef struct {
        logic  updated;
        sum_t  sum;
        mode_t mode;
        logic  start;
        logic  stop;
    } window_result_t;

    // Tracks the window, the running sum and the mode, and checks each result.
    class duty_window_scoreboard;
        entry_t         window_q[WINDOW_LEN];
        slot_t          next_slot;
        sum_t           run_sum;
        mode_t          dir_mode;
        window_result_t sums_due[$];
        int unsigned    failures, requests, results, updates, starts, stops;

        function new();
            foreach (window_q[k]) window_q[k] = '0;
            next_slot = '0;
            run_sum   = '0;
            dir_mode  = MODE_STOP;
            failures  = 0;
            requests  = 0;
            results   = 0;
            updates   = 0;
            starts    = 0;
            stops     = 0;
        endfunction

        // Predicts the result of one accepted capture request.
        function void note_request(logic ch, logic [23:0] data);
            logic           period_edge, duty_edge, overflow;
            logic [14:0]    duty;
            entry_t         entry, old;
            mode_t          own_mode;
            window_result_t r;
            period_edge = data[0];
            duty_edge   = data[1];
            overflow    = data[2];
            duty        = data[17:3];
            own_mode    = ch ? MODE_CCW : MODE_CW;
            r.updated   = 1'b0;
            r.start     = 1'b0;
            r.stop      = 1'b0;
            requests++;

            // A duty edge replaces the oldest entry and adjusts the sum by the difference.
            if (duty_edge) begin
                entry = ch ? -$signed({1'b0, duty}) : $signed({1'b0, duty});
                old   = window_q[next_slot];
                run_sum = run_sum - {{(SUM_W-ENTRY_W){old[ENTRY_W-1]}}, old}
                                  + {{(SUM_W-ENTRY_W){entry[ENTRY_W-1]}}, entry};
                window_q[next_slot] = entry;
                next_slot = (next_slot == slot_t'(WINDOW_LEN - 1)) ? '0 : next_slot + 1'b1;
                r.updated = 1'b1;
                updates++;
                if (dir_mode == MODE_STOP) begin
                    dir_mode = own_mode;
                    r.start  = 1'b1;
                    starts++;
                end
            end

            // A bare overflow of the active channel returns the mode to stop.
            if (overflow && !period_edge && !duty_edge && dir_mode == own_mode) begin
                dir_mode = MODE_STOP;
                r.stop   = 1'b1;
                stops++;
            end

            r.sum  = run_sum;
            r.mode = dir_mode;
            sums_due.push_back(r);
        endfunction

        // Compares one result with the oldest prediction.
        function void check_result(logic [31:0] data);
            window_result_t r;
            results++;
            if (sums_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result %h arrived with nothing predicted", data);
                return;
            end
            r = sums_due.pop_front();
            if (data[0] !== r.updated || data[22:1] !== r.sum || data[24:23] !== r.mode
                    || data[25] !== r.start || data[26] !== r.stop) begin
                failures++;
                if (failures <= 10)
                    $display({"ERROR: result %0d: expected upd=%b sum=%0d mode=%0d ",
                              "start=%b stop=%b, got upd=%b sum=%0d mode=%0d start=%b stop=%b"},
                             results, r.updated, $signed(r.sum), r.mode, r.start, r.stop,
                             data[0], $signed(data[22:1]), data[24:23], data[25], data[26]);
            end
        endfunction

        function int unsigned pending();
            return sums_due.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int unsigned send_idle = 11;
    int unsigned recv_idle = 60;

    duty_window_scoreboard sb = new();

    signed_duty_window_sum_with_direction dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock with a 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Accepted requests feed the predictor; accepted results are checked.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Drives one capture request, with random idle cycles ahead of it.
    task automatic send_capture(input logic ch, input logic pe, input logic de,
                                input logic ov, input logic [14:0] duty);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= ch;
        s_tdata  <= {6'd0, duty, ov, de, pe};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Holds the sender off until every predicted result has been checked.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // Random capture traffic, leaning toward one channel in bursts so the sum swings wide.
    task automatic send_random(input int count);
        logic        lean, ch, pe, de, ov;
        logic [14:0] duty;
        lean = 1'b0;
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0)
                lean = 1'($urandom_range(1));
            ch = ($urandom_range(99) < 85) ? lean : ~lean;
            de = ($urandom_range(99) < 60);
            pe = ($urandom_range(99) < 30);
            ov = ($urandom_range(99) < 25);
            case ($urandom_range(9))
                0:       duty = '0;
                1:       duty = '1;
                default: duty = 15'($urandom);
            endcase
            send_capture(ch, pe, de, ov, duty);
        end
    endtask

    // Run timeout.
    initial begin
        #400_000;
        $display("FAILURE");
        $finish;
    end

    // Main sequence: reset, directed cases, then three random phases.
    initial begin
        int unsigned waited;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed cases covering the mode transitions and the ignored overflows.
        send_capture(1'b0, 1'b0, 1'b0, 1'b0, 15'd0);      // no edge at all
        send_capture(1'b0, 1'b0, 1'b0, 1'b1, 15'd0);      // overflow while stopped
        send_capture(1'b0, 1'b0, 1'b1, 1'b0, 15'h7FFF);   // clockwise start, largest duty
        send_capture(1'b1, 1'b0, 1'b1, 1'b0, 15'h7FFF);   // opposite channel while running
        send_capture(1'b1, 1'b0, 1'b0, 1'b1, 15'd0);      // overflow of the idle channel
        send_capture(1'b0, 1'b1, 1'b0, 1'b1, 15'd0);      // overflow cancelled by period edge
        send_capture(1'b0, 1'b0, 1'b1, 1'b1, 15'd1);      // overflow cancelled by duty edge
        send_capture(1'b0, 1'b0, 1'b0, 1'b1, 15'd0);      // clockwise stop
        send_capture(1'b1, 1'b0, 1'b1, 1'b0, 15'd0);      // counter-clockwise start, zero duty
        send_capture(1'b1, 1'b1, 1'b0, 1'b0, 15'h5555);   // period edge only, duty ignored
        send_capture(1'b1, 1'b0, 1'b0, 1'b1, 15'h2AAA);   // counter-clockwise stop
        send_capture(1'b1, 1'b1, 1'b1, 1'b0, 15'h2AAA);   // start with both edges
        send_capture(1'b0, 1'b0, 1'b0, 1'b1, 15'h7FFF);   // overflow of the idle channel
        send_capture(1'b1, 1'b1, 1'b1, 1'b1, 15'h7FFF);   // every flag at once
        send_capture(1'b1, 1'b0, 1'b0, 1'b1, 15'd0);      // counter-clockwise stop
        send_capture(1'b0, 1'b0, 1'b1, 1'b0, 15'h4000);   // clockwise start again
        send_capture(1'b0, 1'b0, 1'b1, 1'b0, 15'h3FFF);   // further sample while running
        drain_results();

        send_random(185);
        drain_results();

        send_idle = 60;
        recv_idle = 11;
        send_random(185);
        drain_results();

        send_idle = 0;
        recv_idle = 0;
        send_random(185);
        s_tvalid <= 1'b0;

        // Wait for the remaining results, then wait on for anything unexpected.
        waited = 0;
        while (sb.pending() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (8) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("ERROR: %0d predicted results never arrived", sb.pending());
            sb.failures += sb.pending();
        end

        $display("Run covered %0d capture requests and %0d results: %0d window updates,",
                 sb.requests, sb.results, sb.updates);
        $display("  %0d start pulses and %0d stop pulses predicted.", sb.starts, sb.stops);
        if (sb.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

[sim.f]
design/sdws_pkg.sv
design/sdws_window.sv
design/signed_duty_window_sum_with_direction.sv
tb/tb.sv
